// ===== rtl/core/jsr_pkg.sv =====
package jsr_pkg;

    localparam int MAX_DEPTH  = 16;
    localparam int DEPTH_BITS = $clog2(MAX_DEPTH + 1);
    localparam int POS_BITS   = 32;
    localparam int VALUE_BITS = 32;

    localparam logic [7:0] CH_OPEN   = 8'h5B;
    localparam logic [7:0] CH_CLOSE  = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;

    typedef enum logic [2:0] {
        PH_WS,
        PH_INT,
        PH_STR,
        PH_ARR,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        SC_NONE,
        SC_INT,
        SC_STR
    } scalar_t;

    typedef enum logic [1:0] {
        KIND_ERR = 2'd0,
        KIND_INT = 2'd1,
        KIND_STR = 2'd2,
        KIND_ARR = 2'd3
    } kind_t;

    typedef struct packed {
        phase_t                phase;
        logic [DEPTH_BITS-1:0] nest_depth;
        logic                  expect_item;
        scalar_t               inner_scalar;
        logic [POS_BITS-1:0]   byte_offset;
        logic [POS_BITS-1:0]   start_offset;
    } parse_state_t;

    typedef struct packed {
        logic                  valid;
        kind_t                 kind;
        logic [VALUE_BITS-1:0] start;
        logic [VALUE_BITS-1:0] length;
    } parse_result_t;

endpackage

// ===== rtl/core/jsr_stream_if.sv =====
interface jsr_stream_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink (input valid, input in_byte, input end_of_stream, output ready);
endinterface

// ===== rtl/core/jsr_value_if.sv =====
interface jsr_value_if;
    logic        valid;
    logic        ready;
    logic [1:0]  value_kind;
    logic [31:0] value_start;
    logic [31:0] value_length;

    modport source (output valid, output value_kind, output value_start,
                    output value_length, input ready);
    modport sink (input valid, input value_kind, input value_start,
                  input value_length, output ready);
endinterface

// ===== rtl/core/jsr_step.sv =====
module jsr_step (
    input  jsr_pkg::parse_state_t  cur,
    input  logic [7:0]             in_byte,
    input  logic                   end_of_stream,
    output jsr_pkg::parse_state_t  nxt,
    output jsr_pkg::parse_result_t res
);

    logic                            is_space;
    logic                            is_digit;
    logic                            scan_on;
    logic [jsr_pkg::POS_BITS-1:0]    span;
    logic [jsr_pkg::DEPTH_BITS-1:0]  depth_dec;

    assign is_space = (in_byte == jsr_pkg::CH_SPACE) || (in_byte == jsr_pkg::CH_CR) ||
                      (in_byte == jsr_pkg::CH_LF) || (in_byte == jsr_pkg::CH_TAB);
    assign is_digit = (in_byte >= jsr_pkg::CH_ZERO) && (in_byte <= jsr_pkg::CH_NINE);
    assign span     = cur.byte_offset - cur.start_offset;
    assign depth_dec = (cur.nest_depth != '0) ? cur.nest_depth - 1'b1 : cur.nest_depth;

    always_comb
    begin
        nxt          = cur;
        res.valid    = 1'b0;
        res.kind     = jsr_pkg::KIND_ERR;
        res.start    = '0;
        res.length   = '0;
        scan_on      = 1'b1;

        case (cur.phase)
            jsr_pkg::PH_WS:
            begin
                if (!is_space)
                begin
                    nxt.start_offset = cur.byte_offset;
                    if (in_byte == jsr_pkg::CH_OPEN)
                    begin
                        nxt.phase       = jsr_pkg::PH_ARR;
                        nxt.nest_depth  = jsr_pkg::DEPTH_BITS'(1);
                        nxt.expect_item = 1'b1;
                    end
                    else if (in_byte == jsr_pkg::CH_QUOTE)
                        nxt.phase = jsr_pkg::PH_STR;
                    else if (is_digit)
                        nxt.phase = jsr_pkg::PH_INT;
                    else
                        res.valid = 1'b1;
                end
            end
            jsr_pkg::PH_INT:
            begin
                if (!is_digit)
                begin
                    res.valid  = 1'b1;
                    res.kind   = jsr_pkg::KIND_INT;
                    res.start  = jsr_pkg::VALUE_BITS'(cur.start_offset);
                    res.length = jsr_pkg::VALUE_BITS'(span);
                end
            end
            jsr_pkg::PH_STR:
            begin
                if (in_byte == jsr_pkg::CH_QUOTE)
                begin
                    res.valid  = 1'b1;
                    res.kind   = jsr_pkg::KIND_STR;
                    res.start  = jsr_pkg::VALUE_BITS'(cur.start_offset);
                    res.length = jsr_pkg::VALUE_BITS'(span + 1'b1);
                end
            end
            jsr_pkg::PH_ARR:
            begin
                if (cur.inner_scalar == jsr_pkg::SC_STR)
                begin
                    scan_on = 1'b0;
                    if (in_byte == jsr_pkg::CH_QUOTE)
                    begin
                        nxt.inner_scalar = jsr_pkg::SC_NONE;
                        nxt.expect_item  = 1'b0;
                    end
                end
                else if (cur.inner_scalar == jsr_pkg::SC_INT)
                begin
                    if (is_digit)
                        scan_on = 1'b0;
                    else
                    begin
                        nxt.inner_scalar = jsr_pkg::SC_NONE;
                        nxt.expect_item  = 1'b0;
                    end
                end

                if (scan_on && !is_space)
                begin
                    if (in_byte == jsr_pkg::CH_CLOSE)
                    begin
                        nxt.nest_depth  = depth_dec;
                        nxt.expect_item = 1'b0;
                        if (depth_dec == '0)
                        begin
                            res.valid  = 1'b1;
                            res.kind   = jsr_pkg::KIND_ARR;
                            res.start  = jsr_pkg::VALUE_BITS'(cur.start_offset);
                            res.length = jsr_pkg::VALUE_BITS'(span + 1'b1);
                        end
                    end
                    else if (nxt.expect_item)
                    begin
                        if (in_byte == jsr_pkg::CH_OPEN)
                        begin
                            if (cur.nest_depth >= jsr_pkg::DEPTH_BITS'(jsr_pkg::MAX_DEPTH))
                                res.valid = 1'b1;
                            else
                                nxt.nest_depth = cur.nest_depth + 1'b1;
                        end
                        else if (in_byte == jsr_pkg::CH_QUOTE)
                            nxt.inner_scalar = jsr_pkg::SC_STR;
                        else if (is_digit)
                            nxt.inner_scalar = jsr_pkg::SC_INT;
                        else
                            res.valid = 1'b1;
                    end
                    else if (in_byte == jsr_pkg::CH_COMMA)
                        nxt.expect_item = 1'b1;
                    else
                        res.valid = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (res.valid)
            nxt.phase = jsr_pkg::PH_DONE;

        if (end_of_stream)
        begin
            if (nxt.phase != jsr_pkg::PH_DONE)
            begin
                res.valid = 1'b1;
                if (nxt.phase == jsr_pkg::PH_INT)
                begin
                    res.kind   = jsr_pkg::KIND_INT;
                    res.start  = jsr_pkg::VALUE_BITS'(nxt.start_offset);
                    res.length = jsr_pkg::VALUE_BITS'(
                                     cur.byte_offset - nxt.start_offset + 1'b1);
                end
                else
                begin
                    res.kind   = jsr_pkg::KIND_ERR;
                    res.start  = '0;
                    res.length = '0;
                end
            end
            nxt.phase        = jsr_pkg::PH_WS;
            nxt.nest_depth   = '0;
            nxt.expect_item  = 1'b0;
            nxt.inner_scalar = jsr_pkg::SC_NONE;
            nxt.byte_offset  = '0;
            nxt.start_offset = '0;
        end
        else
            nxt.byte_offset = cur.byte_offset + 1'b1;
    end

endmodule

// ===== rtl/core/json_subset_value_recognizer_unit.sv =====
// A byte accepted from stream is held in the input register, parsed combinationally from
// there by jsr_step, and its result is registered before it can be taken on value.
// Throughput: one byte per cycle while value is ready; a result held on value stalls
// the parse, and stream stops after one more byte fills the input register.
// Reset: rst_n clears the parse state, the input register valid and the
// result valid at once; no other initialization pass.
module json_subset_value_recognizer_unit (
    input  logic                clk,
    input  logic                rst_n,
    jsr_stream_if.sink          stream,
    jsr_value_if.source         value
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_eos_reg;
    jsr_pkg::parse_state_t  state_reg;
    jsr_pkg::parse_state_t  state_next;
    jsr_pkg::parse_result_t step_res;
    logic                   res_valid_reg;
    logic                   res_valid_next;
    jsr_pkg::kind_t         res_kind_reg;
    logic [31:0]            res_start_reg;
    logic [31:0]            res_length_reg;
    logic                   advance;
    logic                   work;

    assign advance      = !res_valid_reg || value.ready;
    assign work         = in_valid_reg && advance;
    assign stream.ready = !in_valid_reg || advance;

    jsr_step u_step (
        .cur           (state_reg),
        .in_byte       (in_byte_reg),
        .end_of_stream (in_eos_reg),
        .nxt           (state_next),
        .res           (step_res)
    );

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance)
            res_valid_next = work && step_res.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg           <= 1'b0;
            res_valid_reg          <= 1'b0;
            state_reg.phase        <= jsr_pkg::PH_WS;
            state_reg.nest_depth   <= '0;
            state_reg.expect_item  <= 1'b0;
            state_reg.inner_scalar <= jsr_pkg::SC_NONE;
            state_reg.byte_offset  <= '0;
            state_reg.start_offset <= '0;
        end
        else
        begin
            if (stream.ready)
                in_valid_reg <= stream.valid;
            res_valid_reg <= res_valid_next;
            if (work)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            in_byte_reg <= stream.in_byte;
            in_eos_reg  <= stream.end_of_stream;
        end
        if (work && step_res.valid)
        begin
            res_kind_reg   <= step_res.kind;
            res_start_reg  <= step_res.start;
            res_length_reg <= step_res.length;
        end
    end

    assign value.valid        = res_valid_reg;
    assign value.value_kind   = res_kind_reg;
    assign value.value_start  = res_start_reg;
    assign value.value_length = res_length_reg;

endmodule

// ===== rtl/core/jsr_checker.sv =====
module jsr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  value_kind,
    input logic [31:0] value_start,
    input logic [31:0] value_length
);

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && value_kind == jsr_pkg::KIND_ERR |->
        value_start == '0 && value_length == '0)
        else $error("error result carries nonzero start or length");

    a_len_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (value_kind == jsr_pkg::KIND_STR || value_kind == jsr_pkg::KIND_ARR) |->
        value_length >= 32'd2)
        else $error("string or array shorter than its delimiters");

    a_int_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && value_kind == jsr_pkg::KIND_INT |-> value_length != '0)
        else $error("empty integer result");

    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("stream stalled with no result pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value_kind) &&
        $stable(value_start) && $stable(value_length))
        else $error("result changed while stalled");

endmodule

bind json_subset_value_recognizer_unit jsr_checker u_jsr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (stream.ready),
    .out_valid    (value.valid),
    .out_ready    (value.ready),
    .value_kind   (value.value_kind),
    .value_start  (value.value_start),
    .value_length (value.value_length)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int BYTE_TARGET = 2000;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_AT     = 1000;
    localparam int HOLD_LEN    = 300;

    typedef struct {
        logic [7:0] b;
        logic       eos;
    } byte_req_t;

    typedef struct {
        jsr_pkg::kind_t kind;
        logic [31:0]    start;
        logic [31:0]    length;
    } value_rec_t;

    logic clk;
    logic rst_n;

    jsr_stream_if stream_bus ();
    jsr_value_if  value_bus ();

    json_subset_value_recognizer_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_bus),
        .value  (value_bus)
    );

    byte_req_t  bytes_q[$];
    value_rec_t want_q[$];
    logic [7:0] text_q[$];
    int         queued_cnt;
    int         sent_cnt;
    int         err_cnt = 0;
    int         cyc = 0;
    int         hold_left;
    logic       hold_done;
    logic       hold_on;

    jsr_pkg::phase_t              ph;
    int unsigned                  depth;
    logic                         want_item;
    jsr_pkg::scalar_t             scal;
    logic [jsr_pkg::POS_BITS-1:0] byte_off;
    logic [jsr_pkg::POS_BITS-1:0] st_off;
    logic                         done;

    function automatic bit is_ws(logic [7:0] c);
        return c == jsr_pkg::CH_SPACE || c == jsr_pkg::CH_CR || c == jsr_pkg::CH_LF ||
               c == jsr_pkg::CH_TAB;
    endfunction

    function automatic bit is_dig(logic [7:0] c);
        return c >= jsr_pkg::CH_ZERO && c <= jsr_pkg::CH_NINE;
    endfunction

    function automatic void clear_parse();
        ph        = jsr_pkg::PH_WS;
        depth     = 0;
        want_item = 1'b0;
        scal      = jsr_pkg::SC_NONE;
        byte_off  = '0;
        st_off    = '0;
        done      = 1'b0;
    endfunction

    function automatic void settle(jsr_pkg::kind_t k, logic [jsr_pkg::POS_BITS-1:0] s,
                                   logic [jsr_pkg::POS_BITS-1:0] l);
        value_rec_t r;
        r.kind   = k;
        r.start  = (k == jsr_pkg::KIND_ERR) ? 32'd0 : s[31:0];
        r.length = (k == jsr_pkg::KIND_ERR) ? 32'd0 : l[31:0];
        want_q.push_back(r);
        done = 1'b1;
        ph   = jsr_pkg::PH_DONE;
    endfunction

    function automatic void parse_byte(logic [7:0] c, logic last);
        bit taken;
        taken = 0;
        case (ph)
            jsr_pkg::PH_WS:
            begin
                if (!is_ws(c))
                begin
                    st_off = byte_off;
                    if (c == jsr_pkg::CH_OPEN)
                    begin
                        ph        = jsr_pkg::PH_ARR;
                        depth     = 1;
                        want_item = 1'b1;
                    end
                    else if (c == jsr_pkg::CH_QUOTE)
                        ph = jsr_pkg::PH_STR;
                    else if (is_dig(c))
                        ph = jsr_pkg::PH_INT;
                    else
                        settle(jsr_pkg::KIND_ERR, '0, '0);
                end
            end
            jsr_pkg::PH_INT:
            begin
                if (!is_dig(c))
                    settle(jsr_pkg::KIND_INT, st_off, byte_off - st_off);
            end
            jsr_pkg::PH_STR:
            begin
                if (c == jsr_pkg::CH_QUOTE)
                    settle(jsr_pkg::KIND_STR, st_off, byte_off - st_off + 1);
            end
            jsr_pkg::PH_ARR:
            begin
                if (scal == jsr_pkg::SC_STR)
                begin
                    if (c == jsr_pkg::CH_QUOTE)
                    begin
                        scal      = jsr_pkg::SC_NONE;
                        want_item = 1'b0;
                    end
                    taken = 1;
                end
                else if (scal == jsr_pkg::SC_INT)
                begin
                    if (is_dig(c))
                        taken = 1;
                    else
                    begin
                        scal      = jsr_pkg::SC_NONE;
                        want_item = 1'b0;
                    end
                end
                if (!taken && !is_ws(c))
                begin
                    if (c == jsr_pkg::CH_CLOSE)
                    begin
                        if (depth > 0)
                            depth--;
                        want_item = 1'b0;
                        if (depth == 0)
                            settle(jsr_pkg::KIND_ARR, st_off, byte_off - st_off + 1);
                    end
                    else if (want_item)
                    begin
                        if (c == jsr_pkg::CH_OPEN)
                        begin
                            if (depth >= jsr_pkg::MAX_DEPTH)
                                settle(jsr_pkg::KIND_ERR, '0, '0);
                            else
                                depth++;
                        end
                        else if (c == jsr_pkg::CH_QUOTE)
                            scal = jsr_pkg::SC_STR;
                        else if (is_dig(c))
                            scal = jsr_pkg::SC_INT;
                        else
                            settle(jsr_pkg::KIND_ERR, '0, '0);
                    end
                    else if (c == jsr_pkg::CH_COMMA)
                        want_item = 1'b1;
                    else
                        settle(jsr_pkg::KIND_ERR, '0, '0);
                end
            end
            default:
            begin
            end
        endcase

        if (last)
        begin
            if (!done)
            begin
                if (ph == jsr_pkg::PH_INT)
                    settle(jsr_pkg::KIND_INT, st_off, byte_off - st_off + 1);
                else
                    settle(jsr_pkg::KIND_ERR, '0, '0);
            end
            clear_parse();
        end
        else
            byte_off = byte_off + 1;
    endfunction

    function automatic logic [7:0] ws_char();
        case ($urandom_range(0, 3))
            0: return jsr_pkg::CH_SPACE;
            1: return jsr_pkg::CH_CR;
            2: return jsr_pkg::CH_LF;
            default: return jsr_pkg::CH_TAB;
        endcase
    endfunction

    function automatic void add_ws(int max_n);
        repeat ($urandom_range(0, max_n))
            text_q.push_back(ws_char());
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    function automatic void ship_stream();
        byte_req_t r;
        for (int i = 0; i < text_q.size(); i++)
        begin
            r.b   = text_q[i];
            r.eos = (i == text_q.size() - 1);
            bytes_q.push_back(r);
        end
        queued_cnt += text_q.size();
        text_q.delete();
    endfunction

    function automatic void gen_value(int lvl);
        int         k;
        int         n;
        logic [7:0] b;
        k = $urandom_range(0, (lvl >= 4) ? 1 : 2);
        if (k == 0)
        begin
            repeat ($urandom_range(1, 4))
                text_q.push_back(jsr_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
        else if (k == 1)
        begin
            text_q.push_back(jsr_pkg::CH_QUOTE);
            repeat ($urandom_range(0, 4))
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == jsr_pkg::CH_QUOTE);
                text_q.push_back(b);
            end
            text_q.push_back(jsr_pkg::CH_QUOTE);
        end
        else
        begin
            n = $urandom_range(0, 3);
            text_q.push_back(jsr_pkg::CH_OPEN);
            for (int i = 0; i < n; i++)
            begin
                add_ws(1);
                gen_value(lvl + 1);
                add_ws(1);
                if (i < n - 1 || $urandom_range(0, 3) == 0)
                    text_q.push_back(jsr_pkg::CH_COMMA);
            end
            add_ws(1);
            text_q.push_back(jsr_pkg::CH_CLOSE);
        end
    endfunction

    function automatic void gen_stream();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 90)
        begin
            add_ws(3);
            gen_value(0);
            repeat ($urandom_range(0, 3))
                text_q.push_back(8'($urandom_range(0, 255)));
            if (r >= 80 && text_q.size() > 1)
            begin
                n = $urandom_range(1, text_q.size() - 1);
                repeat (n)
                    void'(text_q.pop_back());
            end
            else if (r >= 70)
                text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
        end
        else if (r < 95)
        begin
            n = $urandom_range(jsr_pkg::MAX_DEPTH - 2, jsr_pkg::MAX_DEPTH + 2);
            repeat (n)
                text_q.push_back(jsr_pkg::CH_OPEN);
            repeat (n)
                text_q.push_back(jsr_pkg::CH_CLOSE);
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                text_q.push_back(8'($urandom_range(0, 255)));
        end
        ship_stream();
    endfunction

    function automatic int idle_mode();
        return (sent_cnt / 256) % 5;
    endfunction

    function automatic bit src_gap();
        int m;
        m = idle_mode();
        if (m == 1)
            return $urandom_range(0, 99) < 62;
        if (m == 3)
            return $urandom_range(0, 99) < 18;
        return 0;
    endfunction

    function automatic bit sink_stall();
        int m;
        m = idle_mode();
        if (m == 2)
            return $urandom_range(0, 99) < 62;
        if (m == 3)
            return $urandom_range(0, 99) < 18;
        return 0;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n      = 1'b0;
        queued_cnt = 0;

        put_str("0");                   ship_stream();
        put_str("123 ");                ship_stream();
        text_q.push_back(jsr_pkg::CH_SPACE);
        text_q.push_back(jsr_pkg::CH_TAB);
        text_q.push_back(jsr_pkg::CH_CR);
        text_q.push_back(jsr_pkg::CH_LF);
        put_str("\"ab\"");              ship_stream();
        put_str("\"\"");                ship_stream();
        put_str("[]");                  ship_stream();
        put_str("[1,\"x\",[2],]");      ship_stream();
        put_str("[,]");                 ship_stream();
        put_str("[1,,2]");              ship_stream();
        put_str("[1 2]");               ship_stream();
        put_str("x");                   ship_stream();
        put_str("   ");                 ship_stream();
        put_str("\"abc");               ship_stream();
        put_str("[1,2");                ship_stream();
        put_str("12]zz");               ship_stream();
        put_str("[]xyz");               ship_stream();
        put_str("[\t");
        text_q.push_back(jsr_pkg::CH_CR);
        put_str("\n1 ]");               ship_stream();
        put_str("\"a");
        text_q.push_back(8'h00);
        put_str("b\"");                 ship_stream();
        text_q.push_back(8'hFF);        ship_stream();
        text_q.push_back(8'h00);        ship_stream();
        repeat (jsr_pkg::MAX_DEPTH)
            text_q.push_back(jsr_pkg::CH_OPEN);
        repeat (jsr_pkg::MAX_DEPTH)
            text_q.push_back(jsr_pkg::CH_CLOSE);
        ship_stream();
        repeat (jsr_pkg::MAX_DEPTH + 1)
            text_q.push_back(jsr_pkg::CH_OPEN);
        text_q.push_back(jsr_pkg::CH_CLOSE);
        ship_stream();

        while (queued_cnt < BYTE_TARGET)
            gen_stream();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (sent_cnt != queued_cnt)
            @(posedge clk);
        while (want_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin : drive_p
        byte_req_t nxt;
        if (!rst_n)
        begin
            stream_bus.valid         <= 1'b0;
            stream_bus.in_byte       <= 8'h00;
            stream_bus.end_of_stream <= 1'b0;
            sent_cnt                 <= 0;
            clear_parse();
        end
        else
        begin
            if (stream_bus.valid && stream_bus.ready)
            begin
                parse_byte(stream_bus.in_byte, stream_bus.end_of_stream);
                sent_cnt <= sent_cnt + 1;
            end
            if (!stream_bus.valid || stream_bus.ready)
            begin
                if (bytes_q.size() != 0 && (hold_on || !src_gap()))
                begin
                    nxt = bytes_q.pop_front();
                    stream_bus.valid         <= 1'b1;
                    stream_bus.in_byte       <= nxt.b;
                    stream_bus.end_of_stream <= nxt.eos;
                end
                else
                    stream_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
            hold_on   <= 1'b0;
        end
        else if (!hold_done && sent_cnt >= HOLD_AT)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
            hold_on   <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            hold_on   <= (hold_left > 1);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_p
        value_rec_t want;
        if (!rst_n)
            value_bus.ready <= 1'b0;
        else
        begin
            if (value_bus.valid && value_bus.ready)
            begin
                if (want_q.size() == 0)
                begin
                    $error("unexpected result: kind %0d start %0d length %0d",
                           value_bus.value_kind, value_bus.value_start,
                           value_bus.value_length);
                    err_cnt++;
                end
                else
                begin
                    want = want_q.pop_front();
                    if (value_bus.value_kind !== want.kind)
                    begin
                        $error("value_kind: expected %0d, actual %0d",
                               want.kind, value_bus.value_kind);
                        err_cnt++;
                    end
                    if (value_bus.value_start !== want.start)
                    begin
                        $error("value_start: expected %0d, actual %0d",
                               want.start, value_bus.value_start);
                        err_cnt++;
                    end
                    if (value_bus.value_length !== want.length)
                    begin
                        $error("value_length: expected %0d, actual %0d",
                               want.length, value_bus.value_length);
                        err_cnt++;
                    end
                end
            end
            value_bus.ready <= !(hold_on || sink_stall());
        end
    end

    always @(posedge clk)
    begin
        cyc++;
        if (cyc >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
rtl/core/jsr_pkg.sv
rtl/core/jsr_stream_if.sv
rtl/core/jsr_value_if.sv
rtl/core/jsr_step.sv
rtl/core/json_subset_value_recognizer_unit.sv
rtl/core/jsr_checker.sv
dv/tb_top.sv
